// ----- rtl/glw_pkg.sv -----
package glw_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_SPAN   = 31;

  // Step counters and spans cover 0..MAX_SPAN.
  localparam int SPAN_BITS  = $clog2(MAX_SPAN + 1);
  // (2*ix+1)*ny stays below 2^(2*SPAN_BITS+1).
  localparam int PROD_BITS  = 2 * SPAN_BITS + 1;
  // Difference of two coordinates needs one extra bit.
  localparam int DIFF_BITS  = COORD_BITS + 1;

  typedef struct packed {
    logic load;     // capture the end points of a new segment
    logic diff;     // form the coordinate differences
    logic prep;     // form spans, directions and the first pixel
    logic advance;  // take one step along the path
  } glw_cmd_t;

  typedef struct packed {
    logic last;     // current pixel ends the run
    logic err;      // current result is a span error
  } glw_status_t;

endpackage

// ----- rtl/glw_ctrl.sv -----
module glw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  glw_pkg::glw_status_t status,
  output glw_pkg::glw_cmd_t    cmd
);
  import glw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == ST_IDLE) && in_tvalid && in_tready_r;
    cmd.diff    = (state_r == ST_DIFF);
    cmd.prep    = (state_r == ST_PREP);
    cmd.advance = (state_r == ST_EMIT) && out_tready && !status.last && !status.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= ST_DIFF;
            in_tready_r <= 1'b0;
          end
        end
        ST_DIFF: begin
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          state_r      <= ST_EMIT;
          out_tvalid_r <= 1'b1;
        end
        ST_EMIT: begin
          // drop back to idle once the final beat is taken
          if (out_tready && (status.last || status.err)) begin
            state_r      <= ST_IDLE;
            out_tvalid_r <= 1'b0;
            in_tready_r  <= 1'b1;
          end
        end
        default: begin
          state_r      <= ST_IDLE;
          out_tvalid_r <= 1'b0;
          in_tready_r  <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/glw_datapath.sv -----
module glw_datapath (
  input  logic                                clk,
  input  glw_pkg::glw_cmd_t                   cmd,
  input  logic signed [glw_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [glw_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [glw_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [glw_pkg::COORD_BITS-1:0] end_y,
  output logic signed [glw_pkg::COORD_BITS-1:0] pixel_x,
  output logic signed [glw_pkg::COORD_BITS-1:0] pixel_y,
  output glw_pkg::glw_status_t                status
);
  import glw_pkg::*;

  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [DIFF_BITS-1:0]  dx_r, dy_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic [SPAN_BITS-1:0]         nx_r, ny_r, ix_r, iy_r;
  logic [PROD_BITS-1:0]         ax_r, by_r;
  logic                         x_neg_r, y_neg_r;
  logic                         last_r, err_r;

  logic [DIFF_BITS-1:0]         absx, absy;
  logic                         span_bad;
  logic                         step_x;
  logic [SPAN_BITS-1:0]         ix_nxt, iy_nxt;
  logic signed [COORD_BITS-1:0] incx, incy;

  assign absx     = dx_r[DIFF_BITS-1] ? DIFF_BITS'(-dx_r) : DIFF_BITS'(dx_r);
  assign absy     = dy_r[DIFF_BITS-1] ? DIFF_BITS'(-dy_r) : DIFF_BITS'(dy_r);
  assign span_bad = (absx > DIFF_BITS'(MAX_SPAN)) || (absy > DIFF_BITS'(MAX_SPAN));

  // step x while (2*ix+1)*ny < (2*iy+1)*nx; ties go to y
  assign step_x = ax_r < by_r;
  assign ix_nxt = step_x ? ix_r + SPAN_BITS'(1) : ix_r;
  assign iy_nxt = step_x ? iy_r : iy_r + SPAN_BITS'(1);
  assign incx   = x_neg_r ? '1 : COORD_BITS'(1);
  assign incy   = y_neg_r ? '1 : COORD_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= start_x;
      sy_r <= start_y;
      ex_r <= end_x;
      ey_r <= end_y;
    end
    if (cmd.diff) begin
      dx_r <= DIFF_BITS'(ex_r) - DIFF_BITS'(sx_r);
      dy_r <= DIFF_BITS'(ey_r) - DIFF_BITS'(sy_r);
    end
    if (cmd.prep) begin
      nx_r    <= absx[SPAN_BITS-1:0];
      ny_r    <= absy[SPAN_BITS-1:0];
      ix_r    <= '0;
      iy_r    <= '0;
      ax_r    <= PROD_BITS'(absy[SPAN_BITS-1:0]);
      by_r    <= PROD_BITS'(absx[SPAN_BITS-1:0]);
      x_neg_r <= dx_r[DIFF_BITS-1];
      y_neg_r <= dy_r[DIFF_BITS-1];
      err_r   <= span_bad;
      last_r  <= !span_bad && (absx == '0) && (absy == '0);
      px_r    <= span_bad ? '0 : sx_r;
      py_r    <= span_bad ? '0 : sy_r;
    end
    if (cmd.advance) begin
      ix_r   <= ix_nxt;
      iy_r   <= iy_nxt;
      last_r <= (ix_nxt == nx_r) && (iy_nxt == ny_r);
      if (step_x) begin
        px_r <= px_r + incx;
        ax_r <= ax_r + PROD_BITS'({ny_r, 1'b0});
      end else begin
        py_r <= py_r + incy;
        by_r <= by_r + PROD_BITS'({nx_r, 1'b0});
      end
    end
  end

  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign status.last = last_r;
  assign status.err  = err_r;

endmodule

// ----- rtl/grid_line_walker_unit.sv -----
// Four-connected line walker.
// Input channel (in_*): one beat carries a segment, start_x, start_y, end_x,
// end_y, each a 16-bit two's complement coordinate.
// Output channel (out_*): a run of beats, one pixel each, walking from the
// start point to the end point with every step along exactly one axis.
// The final pixel (the end point) carries out_tlast. A run holds
// |dx|+|dy|+1 beats, at most 63 with a span limit of 31.
// If either span exceeds the limit the run is a single beat with out_tuser
// set, zero coordinates and out_tlast low.
// Timing: the segment is captured at the edge that accepts the input beat,
// and the difference and span setup steps are then registered in turn before
// the first pixel is valid. After that one pixel leaves per cycle while the
// receiver takes them; the step decision is an incremental compare of two
// running products, updated with each pixel taken. One segment is in flight
// at a time: in_tready is high only while no run is pending.
// A receiver stall holds the current pixel on out_tdata and freezes the walk.
// Reset (rst_n low, synchronous) returns the controller to idle with
// in_tready high and out_tvalid low; no results are pending after reset.
module grid_line_walker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_x[15:0], pixel_y[31:16]
  output logic        out_tlast,  // last_pixel
  output logic        out_tuser   // span_error
);
  import glw_pkg::*;

  glw_cmd_t                     cmd;
  glw_status_t                  status;
  logic signed [COORD_BITS-1:0] pixel_x, pixel_y;

  glw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // unpack the segment, lowest field first
  glw_datapath u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .start_x (in_tdata[COORD_BITS-1:0]),
    .start_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x   (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y   (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .status  (status)
  );

  assign out_tdata = {pixel_y, pixel_x};
  assign out_tlast = status.last;
  assign out_tuser = status.err;

endmodule

// ----- sim/grid_line_walker_unit_tb.sv -----
`timescale 1ns / 1ps

module grid_line_walker_unit_tb;
  import glw_pkg::*;

  // Cycle budget for the whole run. It covers the slowest legal run, roughly
  // 450 segments each with the longest sender gap, the setup and 63 pixels
  // under the longest receiver stalls, plus one long hold-off.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Drain wait after the last pixel.
  localparam int SETTLE_CYCLES = 20;
  // Cap on printed mismatch lines. Every mismatch is still counted.
  localparam int PRINT_LIMIT   = 40;

  // One segment, laid out as on in_tdata: start_x in the lowest bits.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_x;
  } segment_t;

  // One expected pixel of a walk.
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         err;
  } walk_pixel_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // pixel_x[15:0], pixel_y[31:16]
  logic        out_tlast;         // last_pixel
  logic        out_tuser;         // span_error

  walk_pixel_t pending_pixels[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  // Idle knobs: the largest number of cycles each side may wait per beat,
  // and a one-shot long hold-off for the receiver.
  int          tx_max_gap     = 0;
  int          rx_max_stall   = 0;
  int          rx_hold_cycles = 0;

  grid_line_walker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected",
               cycle_count, pending_pixels.size());
      $display("grid_line_walker_unit: mismatch");
      $finish;
    end
  end

  // Walk the segment the way the block should and queue every pixel.
  // A tie in the step rule goes to y; an oversized span yields one error beat.
  function automatic void predict_walk(segment_t seg);
    int          sx, sy, ex, ey;
    int          nx, ny, dir_x, dir_y;
    int          ix, iy;
    walk_pixel_t pix;
    sx = seg.start_x;
    sy = seg.start_y;
    ex = seg.end_x;
    ey = seg.end_y;
    nx = (ex >= sx) ? ex - sx : sx - ex;
    ny = (ey >= sy) ? ey - sy : sy - ey;
    dir_x = (ex > sx) ? 1 : ((ex < sx) ? -1 : 0);
    dir_y = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
    ix = 0;
    iy = 0;
    if (nx > MAX_SPAN || ny > MAX_SPAN) begin
      pix.x    = '0;
      pix.y    = '0;
      pix.last = 1'b0;
      pix.err  = 1'b1;
      pending_pixels.push_back(pix);
      return;
    end
    pix.x    = COORD_BITS'(sx);
    pix.y    = COORD_BITS'(sy);
    pix.last = (nx == 0 && ny == 0);
    pix.err  = 1'b0;
    pending_pixels.push_back(pix);
    while (ix < nx || iy < ny) begin
      if ((1 + 2 * ix) * ny < (1 + 2 * iy) * nx) begin
        sx += dir_x;
        ix++;
      end else begin
        sy += dir_y;
        iy++;
      end
      pix.x    = COORD_BITS'(sx);
      pix.y    = COORD_BITS'(sy);
      pix.last = (ix >= nx && iy >= ny);
      pending_pixels.push_back(pix);
    end
  endfunction

  function automatic segment_t make_segment(int sx, int sy, int ex, int ey);
    segment_t seg;
    seg.start_x = COORD_BITS'(sx);
    seg.start_y = COORD_BITS'(sy);
    seg.end_x   = COORD_BITS'(ex);
    seg.end_y   = COORD_BITS'(ey);
    return seg;
  endfunction

  // Pick an end coordinate at the given offset; flip the offset if it
  // would leave the 16-bit range.
  function automatic int offset_coord(int base, int delta);
    int pos;
    pos = base + delta;
    if (pos > 32767 || pos < -32768) pos = base - delta;
    return pos;
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(65535, 0)) - 32768;
  endfunction

  // Mostly walkable segments with random content, some near the range
  // edges, and a share with spans past the limit.
  function automatic segment_t random_segment();
    int kind, sx, sy, dx, dy;
    kind = int'($urandom_range(99, 0));
    sx = random_coord();
    sy = random_coord();
    if (kind < 45) begin
      dx = int'($urandom_range(14, 0)) - 7;
      dy = int'($urandom_range(14, 0)) - 7;
    end else if (kind < 80) begin
      dx = int'($urandom_range(62, 0)) - 31;
      dy = int'($urandom_range(62, 0)) - 31;
    end else if (kind < 90) begin
      // hug the range edges so the high and low bits both move
      sx = $urandom_range(1, 0) ? 32767 - int'($urandom_range(31, 0))
                                : -32768 + int'($urandom_range(31, 0));
      sy = $urandom_range(1, 0) ? 32767 - int'($urandom_range(31, 0))
                                : -32768 + int'($urandom_range(31, 0));
      dx = int'($urandom_range(62, 0)) - 31;
      dy = int'($urandom_range(62, 0)) - 31;
    end else if (kind < 96) begin
      // one span just past the limit or far past it
      dx = int'($urandom_range(62, 0)) - 31;
      dy = MAX_SPAN + 1 + int'($urandom_range(3, 0) == 0 ? $urandom_range(30000, 0) : 0);
      if ($urandom_range(1, 0)) dy = -dy;
      if ($urandom_range(1, 0)) begin
        kind = dx;
        dx   = dy;
        dy   = kind;
      end
    end else begin
      return make_segment(sx, sy, random_coord(), random_coord());
    end
    return make_segment(sx, sy, offset_coord(sx, dx), offset_coord(sy, dy));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare every accepted pixel with the oldest expectation.
  // Signals are sampled before the edge updates land, so no race.
  always @(posedge clk) begin : check_beat
    walk_pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("beat with nothing pending, pixel_x",
                        int'($signed(out_tdata[15:0])), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[15:0] !== want.x)
          report_mismatch("pixel_x", int'($signed(out_tdata[15:0])), int'(want.x));
        if (out_tdata[31:16] !== want.y)
          report_mismatch("pixel_y", int'($signed(out_tdata[31:16])), int'(want.y));
        if (out_tlast !== want.last)
          report_mismatch("last_pixel", int'(out_tlast), int'(want.last));
        if (out_tuser !== want.err)
          report_mismatch("span_error", int'(out_tuser), int'(want.err));
      end
    end
  end

  // Receiver: wait a random number of cycles before each beat, plus any
  // long hold-off the running test asks for, then take one beat.
  initial begin : pixel_sink
    int wait_cycles;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles    = rx_hold_cycles + int'($urandom_range(rx_max_stall, 0));
      rx_hold_cycles = 0;
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Offer one segment after a random gap and hold it until accepted.
  // Keep tvalid high across back-to-back beats; lower it only for a gap.
  task automatic send_segment(segment_t seg);
    int gap;
    gap = int'($urandom_range(tx_max_gap, 0));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seg;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_walk(seg);
  endtask

  // Drop tvalid and hold the sender until every queued pixel has left.
  task automatic wait_walks_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Extremes, both axes alone, ties, spans at and just past the limit,
  // and zero-length segments at the corners of the range.
  task automatic test_directed();
    tx_max_gap   = 2;
    rx_max_stall = 2;
    send_segment(make_segment(0, 0, 0, 0));
    send_segment(make_segment(-32768, -32768, -32768, -32768));
    send_segment(make_segment(32767, 32767, 32767, 32767));
    send_segment(make_segment(10, 20, 41, 51));
    send_segment(make_segment(41, 51, 10, 20));
    send_segment(make_segment(-5, 7, 26, 7));
    send_segment(make_segment(-5, 7, -5, -24));
    send_segment(make_segment(0, 0, 3, 3));
    send_segment(make_segment(0, 0, -3, 3));
    send_segment(make_segment(0, 0, 1, 31));
    send_segment(make_segment(0, 0, -31, 1));
    send_segment(make_segment(0, 0, 2, 1));
    send_segment(make_segment(-32768, -32768, -32737, -32737));
    send_segment(make_segment(32767, 32767, 32736, 32736));
    send_segment(make_segment(-32768, 32767, -32737, 32736));
    send_segment(make_segment(0, 0, 32, 0));
    send_segment(make_segment(0, 0, 0, -32));
    send_segment(make_segment(100, 100, 132, 132));
    send_segment(make_segment(-32768, -32768, 32767, 32767));
    send_segment(make_segment(32767, -32768, -32768, 32767));
    send_segment(make_segment(-1, -1, 0, 0));
    send_segment(make_segment(0, 0, -1, -1));
    wait_walks_done();
  endtask

  // Random segments with random idling on both sides.
  task automatic test_random_idle(int count);
    tx_max_gap   = 14;
    rx_max_stall = 14;
    repeat (count) send_segment(random_segment());
    wait_walks_done();
  endtask

  // Random segments at full rate: no idling on either side.
  task automatic test_full_rate(int count);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    repeat (count) send_segment(random_segment());
    wait_walks_done();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering segments, so the block fills and stalls its input.
  task automatic test_backpressure(int count);
    tx_max_gap     = 0;
    rx_max_stall   = 3;
    rx_hold_cycles = 400;
    repeat (count) send_segment(random_segment());
    wait_walks_done();
  endtask

  // Let the block run dry between short bursts.
  task automatic test_bursts(int bursts, int per_burst);
    tx_max_gap   = 4;
    rx_max_stall = 6;
    repeat (bursts) begin
      repeat (per_burst) send_segment(random_segment());
      wait_walks_done();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_idle(200);
    test_full_rate(100);
    test_backpressure(40);
    test_bursts(8, 10);

    wait_walks_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("grid_line_walker_unit: match");
    end else begin
      $display("grid_line_walker_unit: mismatch");
    end
    $finish;
  end

endmodule
